// ===== design/xyz_to_lab_d50_unit_assert.svh =====
// Assertion macros for the XYZ to Lab D50 unit checker.
// Included by the checker file; no other dependencies.
`ifndef XYZ_TO_LAB_D50_UNIT_ASSERT_SVH
`define XYZ_TO_LAB_D50_UNIT_ASSERT_SVH
// Plain implication checked on every clock edge outside reset.
`define XL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication checked outside reset.
`define XL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

// ===== design/xl_pkg.sv =====
// Shared types and constants for the XYZ to Lab unit.
// No dependencies.
package xl_pkg;
    localparam int SCALE_BITS = 14;
    localparam int FRAC_BITS = 40;
    localparam int NUM_CELLS = 22;
    localparam logic signed [63:0] UNIT_SHIFT = 64'sd1 <<< (FRAC_BITS - SCALE_BITS);
    localparam logic signed [63:0] RECIP_X = (UNIT_SHIFT * 10000 + 4821) / 9642;
    localparam logic signed [63:0] RECIP_Z = (UNIT_SHIFT * 10000 + 4125) / 8251;
    localparam logic signed [63:0] ONE_Q40 = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] FOUR_29THS = ((64'sd4 <<< FRAC_BITS) + 14) / 29;
    localparam logic signed [63:0] OUT_DIV = UNIT_SHIFT * 100;
    localparam logic signed [63:0] KNEE = 64'sd216 * ONE_Q40;

    // Linear segment: each component scale times 841, split into a quotient
    // and a remainder of 108, so that only a small product is divided.
    localparam logic [29:0] LIN_Q_X = 30'((RECIP_X * 841) / 108);
    localparam logic [6:0]  LIN_R_X = 7'((RECIP_X * 841) % 108);
    localparam logic [29:0] LIN_Q_Y = 30'((UNIT_SHIFT * 841) / 108);
    localparam logic [6:0]  LIN_R_Y = 7'((UNIT_SHIFT * 841) % 108);
    localparam logic [29:0] LIN_Q_Z = 30'((RECIP_Z * 841) / 108);
    localparam logic [6:0]  LIN_R_Z = 7'((RECIP_Z * 841) % 108);

    // Reciprocals rounded up, exact for numerators below 2^22 with a 29-bit shift.
    localparam logic [22:0] RECIP_108 = 23'd4971027;
    localparam logic [22:0] RECIP_100 = 23'd5368710;
    // Largest whole-unit magnitude kept before the output divide; beyond it
    // the result saturates either way.
    localparam logic [21:0] SAT_WHOLE_MAX = 22'd3276899;

    // Per-component state carried down the cell chain.
    typedef struct packed {
        logic        cube;  // cube-root branch taken
        logic [1:0]  k;     // range-reduction shift count
        logic [63:0] rem;   // remaining radicand
        logic [21:0] root;  // partial root
        logic signed [63:0] lin;  // linear segment result
    } t_comp;

    typedef struct packed {
        t_comp cx;
        t_comp cy;
        t_comp cz;
    } t_lane;

    // Linear segment parts of one component, taken from its magnitude.
    typedef struct packed {
        logic        neg;  // component was negative
        logic [45:0] hi;   // magnitude times the whole quotient
        logic [21:0] lo;   // magnitude times the remainder, still to divide by 108
    } t_lin;
endpackage

// ===== design/xl_cell.sv =====
// One cube-root digit step for three components, registered.
// Depends on xl_pkg.
module xl_cell
    import xl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  logic [5:0] i_shift,
    input  t_lane i_lane,
    output t_lane o_lane
);
    function automatic t_comp step(t_comp c, logic [5:0] s);
        logic [21:0] y;
        logic [63:0] b;
        t_comp r;
        r = c;
        y = {c.root[20:0], 1'b0};
        b = 64'(3) * 64'(y) * (64'(y) + 64'd1) + 64'd1;
        if ((c.rem >> s) >= b) begin
            r.rem = c.rem - (b << s);
            y = y + 22'd1;
        end
        r.root = y;
        return r;
    endfunction

    // Advance every component by one root bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane.cx <= step(i_lane.cx, i_shift);
            o_lane.cy <= step(i_lane.cy, i_shift);
            o_lane.cz <= step(i_lane.cz, i_shift);
        end
    end
endmodule

// ===== design/xyz_to_lab_d50_unit.sv =====
// Top level of the XYZ to Lab D50 converter: front end, cell chain, output stage.
// Depends on xl_pkg and xl_cell.
//   channel | dir | fields
//   s_axis  | in  | x_value, y_value, z_value
//   m_axis  | out | l_star, a_star, b_star
// One item per cycle while the output is not stalled. There are NUM_CELLS + 4
// register stages (input, prep, 22 root cells, combine, output).
// Synchronous active-low reset clears valid bits only.
// The whole pipe advances when the output register is empty or taken.
module xyz_to_lab_d50_unit
    import xl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata, // x_value, y_value, z_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata  // l_star, a_star, b_star
);
    localparam int NST = NUM_CELLS + 4;
    logic en;
    logic [NST-1:0] r_vld;
    logic signed [63:0] r_tx, r_ty, r_tz;
    t_lin r_px, r_py, r_pz;
    t_lane lanes [0:NUM_CELLS];
    logic signed [63:0] r_l, r_a, r_b;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NST-1];

    // Valid bits through the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Magnitude times the split constant; the sign is applied after the divide.
    function automatic t_lin lin_split(logic [15:0] v, logic [29:0] q, logic [6:0] rm);
        t_lin p;
        logic [15:0] mag;
        mag = v[15] ? 16'(-v) : v;
        p.neg = v[15];
        p.hi = 46'(mag) * 46'(q);
        p.lo = 22'(mag) * 22'(rm);
        return p;
    endfunction

    // Normalize components to Q.40.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx <= 64'(signed'(s_axis_tdata[15:0])) * RECIP_X;
            r_ty <= 64'(signed'(s_axis_tdata[31:16])) * UNIT_SHIFT;
            r_tz <= 64'(signed'(s_axis_tdata[47:32])) * RECIP_Z;
            r_px <= lin_split(s_axis_tdata[15:0], LIN_Q_X, LIN_R_X);
            r_py <= lin_split(s_axis_tdata[31:16], LIN_Q_Y, LIN_R_Y);
            r_pz <= lin_split(s_axis_tdata[47:32], LIN_Q_Z, LIN_R_Z);
        end
    end

    function automatic t_comp prep(logic signed [63:0] t, t_lin p);
        t_comp c;
        logic [63:0] u;
        logic [1:0] k;
        logic [44:0] prod;
        logic [46:0] lin_mag;
        logic signed [63:0] lin_s;
        u = t;
        k = 2'd0;
        c.cube = (t * 64'sd24389) > KNEE;
        for (int i = 0; i < 3; i++) begin
            if (u >= 64'(ONE_Q40)) begin
                u = u >> 3;
                k = k + 2'd1;
            end
        end
        c.k = k;
        c.rem = u << 23;
        c.root = '0;
        // Linear segment, truncated toward zero: the remainder part is divided
        // by 108 through a reciprocal multiply.
        prod = 45'(p.lo) * 45'(RECIP_108);
        lin_mag = 47'(p.hi) + 47'(prod[44:29]);
        lin_s = signed'(64'(lin_mag));
        c.lin = (p.neg ? -lin_s : lin_s) + FOUR_29THS;
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            lanes[0].cx <= prep(r_tx, r_px);
            lanes[0].cy <= prep(r_ty, r_py);
            lanes[0].cz <= prep(r_tz, r_pz);
        end
    end

    // Chain of root cells, one root bit per cell.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        xl_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_shift(6'(63 - 3 * g)),
            .i_lane (lanes[g]),
            .o_lane (lanes[g+1])
        );
    end

    function automatic logic signed [63:0] fin(t_comp c);
        return c.cube ? signed'(64'(c.root) << (19 + c.k)) : c.lin;
    endfunction

    // Divide by 100 * 2^26 toward zero and saturate to 16 bits.
    function automatic logic [15:0] sat(logic signed [63:0] v);
        logic [63:0] mag;
        logic [21:0] whole;
        logic [44:0] prod;
        logic [15:0] quo;
        logic [15:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        whole = (mag[63:26] > 38'(SAT_WHOLE_MAX)) ? SAT_WHOLE_MAX : mag[47:26];
        prod = 45'(whole) * 45'(RECIP_100);
        quo = prod[44:29];
        if (v[63]) begin
            res = 16'(-quo);
        end else begin
            res = (quo > 16'd32767) ? 16'h7FFF : quo;
        end
        return res;
    endfunction

    // Combine f values, then scale and saturate.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l <= 64'sd116 * fin(lanes[NUM_CELLS].cy) - 64'sd16 * ONE_Q40;
            r_a <= 64'sd500 * (fin(lanes[NUM_CELLS].cx) - fin(lanes[NUM_CELLS].cy));
            r_b <= 64'sd200 * (fin(lanes[NUM_CELLS].cy) - fin(lanes[NUM_CELLS].cz));
            m_axis_tdata <= {sat(r_b), sat(r_a), sat(r_l)};
        end
    end
endmodule

// ===== design/xl_checker.sv =====
// Port-level checker for the XYZ to Lab unit, bound to the top level.
// Depends on xyz_to_lab_d50_unit_assert.svh.
`include "xyz_to_lab_d50_unit_assert.svh"
module xl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    `XL_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `XL_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `XL_ASSERT_IMP(a_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind xyz_to_lab_d50_unit xl_checker u_chk (.*);

// ===== tb/tb_xyz_to_lab_d50_unit.sv =====
// Self-checking testbench for the XYZ to Lab D50 converter.
// Predicts L*, a*, b* per pixel in fixed point and checks the output stream in order.
// Depends on xl_pkg and xyz_to_lab_d50_unit.
module tb_xyz_to_lab_d50_unit;
    import xl_pkg::*;

    localparam int LATENCY = NUM_CELLS + 4;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // x_value, y_value, z_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;  // l_star, a_star, b_star

    logic [47:0] pixel_queue[$];
    logic [47:0] lab_queue[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    bit          send_pause;
    bit          failed;
    longint      cycle_count;

    xyz_to_lab_d50_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Floor integer cube root of a 64-bit radicand, three bits per step.
    function automatic logic [63:0] cube_root_floor(logic [63:0] rad);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int s = 63; s >= 0; s -= 3) begin
            root = root << 1;
            trial = 3 * root * (root + 1) + 1;
            if ((rad >> s) >= trial) begin
                rad = rad - (trial << s);
                root = root + 1;
            end
        end
        return root;
    endfunction

    // Lab f() on a Q.40 value: cube root above the knee, linear segment below.
    function automatic longint lab_curve(longint t);
        logic [63:0] u;
        int shifts;
        if (t * 24389 > 216 * ONE_Q40) begin
            u = t;
            shifts = 0;
            for (int i = 0; i < 4; i++) begin
                if (u >= ONE_Q40) begin
                    u = u >> 3;
                    shifts++;
                end
            end
            return longint'(cube_root_floor(u << 23) << (19 + shifts));
        end
        return (t * 841) / 108 + FOUR_29THS;
    endfunction

    // Scale a Q.40 Lab value to the output grid, truncate and saturate.
    function automatic logic [15:0] lab_to_output(longint v);
        longint q;
        q = v / OUT_DIV;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Expected Lab triple for one XYZ pixel.
    function automatic logic [47:0] predict_lab(logic [47:0] xyz);
        longint fx, fy, fz;
        fx = lab_curve(longint'($signed(xyz[15:0])) * RECIP_X);
        fy = lab_curve(longint'($signed(xyz[31:16])) * UNIT_SHIFT);
        fz = lab_curve(longint'($signed(xyz[47:32])) * RECIP_Z);
        return {lab_to_output(200 * (fy - fz)), lab_to_output(500 * (fx - fy)),
                lab_to_output(116 * fy - 16 * ONE_Q40)};
    endfunction

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: offer the head of the pending queue, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lab_queue.push_back(predict_lab(s_axis_tdata));
                void'(pixel_queue.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) || pixel_queue.size() == 0) begin
                if (s_axis_tvalid && s_axis_tready && pixel_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_queue.size() > 0 && !send_pause
                             && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pixel_queue[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: accept results, check against the oldest prediction.
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (lab_queue.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    want = lab_queue.pop_front();
                    for (int f = 0; f < 3; f++) begin
                        if (want[f*16 +: 16] !== m_axis_tdata[f*16 +: 16]) begin
                            $display("%0t: field %0d expected %0d actual %0d", $time, f,
                                     $signed(want[f*16 +: 16]),
                                     $signed(m_axis_tdata[f*16 +: 16]));
                            failed = 1'b1;
                        end
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_pixel(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        pixel_queue.push_back({z, y, x});
    endtask

    // Random pixel: mostly physical colors, sometimes near-black values and raw noise.
    task automatic add_random_pixel();
        int mode;
        mode = $urandom_range(9);
        if (mode < 6)
            add_pixel(16'($urandom_range(20000)), 16'($urandom_range(20000)),
                      16'($urandom_range(20000)));
        else if (mode < 8)
            add_pixel(16'($urandom_range(200)), 16'($urandom_range(200)),
                      16'($urandom_range(200)));
        else
            add_pixel(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || lab_queue.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        logic [15:0] edges[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000,
                                  16'h7FFF, 16'h4000, 16'h0092, 16'h0091};
        failed = 1'b0;
        cycle_count = 0;
        hold_cycles = 0;
        send_pause = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 77;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;

        // Directed: extremes, white point, values around the knee.
        for (int i = 0; i < 8; i++) add_pixel(edges[i], edges[i], edges[i]);
        add_pixel(16'h7FFF, 16'h0000, 16'h8000);
        add_pixel(16'h8000, 16'h7FFF, 16'h7FFF);
        add_pixel(16'h0000, 16'h7FFF, 16'h8000);
        add_pixel(16'd15798, 16'd16384, 16'd13519);
        add_pixel(16'h7FFF, 16'h8000, 16'h0000);
        add_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        add_pixel(16'h5555, 16'hAAAA, 16'h5555);
        @(posedge i_rst_n);
        for (int i = 0; i < 350; i++) add_random_pixel();
        wait_drained();

        // Long output stall while the sender keeps offering.
        send_idle_pct = 77;
        recv_idle_pct = 23;
        for (int i = 0; i < 60; i++) add_random_pixel();
        hold_cycles = 3 * LATENCY;
        for (int i = 0; i < 300; i++) add_random_pixel();
        wait_drained();

        // Sender pause while new pixels queue up, then full rate.
        send_pause = 1'b1;
        for (int i = 0; i < 20; i++) add_random_pixel();
        repeat (LATENCY) @(posedge i_clk);
        send_pause = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 360; i++) add_random_pixel();
        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);

        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/xl_pkg.sv
design/xl_cell.sv
design/xyz_to_lab_d50_unit.sv
design/xl_checker.sv
tb/tb_xyz_to_lab_d50_unit.sv
